FILE: design/rk4c_pkg.sv
// shared types, constants and helper functions of the rk4 oscillator integrator
package rk4c_pkg;

  // fixed-point formats
  localparam int Q_FRAC  = 24;
  localparam int DATA_W  = 32;
  localparam int STEP_W  = 31;
  localparam int TIME_W  = 48;
  localparam int OPND_W  = DATA_W + 1;
  localparam int PROD_W  = 2 * OPND_W - Q_FRAC;
  localparam int WIDE_W  = PROD_W + 2;
  localparam int SUM_W   = DATA_W + 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TIME_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUPLING   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_POS_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_POS_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VEL_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VEL_Y = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_END_TIME   = 3'd7;

  // register reset values
  localparam logic [STEP_W-1:0]        RST_STEP_SIZE  = 31'd16777216;
  localparam logic signed [DATA_W-1:0] RST_COUPLING   = 32'sd1730;
  localparam logic signed [DATA_W-1:0] RST_STIFFNESS  = 32'sd4028210;
  localparam logic signed [DATA_W-1:0] RST_INIT_POS_X = 32'sd83886080;
  localparam logic [TIME_W-1:0]        RST_END_TIME   = 48'd5033164800;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_size;
    data_t             coupling_coeff;
    data_t             stiffness_coeff;
    data_t             init_pos_x;
    data_t             init_pos_y;
    data_t             init_vel_x;
    data_t             init_vel_y;
    logic [TIME_W-1:0] end_time;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] sim_time;
    data_t             pos_x;
    data_t             pos_y;
    data_t             vel_x;
    data_t             vel_y;
    logic              saturated;
    logic              last;
  } res_t;

  typedef struct packed {
    logic start;
    logic restart;
    logic take;
  } ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } stat_t;

  typedef struct packed {
    logic  clip;
    data_t val;
  } sat_t;

  // sign extension helpers
  function automatic opnd_t ext_op(input data_t d);
    return {{(OPND_W-DATA_W){d[DATA_W-1]}}, d};
  endfunction

  function automatic wide_t ext_wide(input data_t d);
    return {{(WIDE_W-DATA_W){d[DATA_W-1]}}, d};
  endfunction

  function automatic wide_t ext_prod(input prod_t p);
    return {{(WIDE_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  function automatic sum_t ext_sum(input data_t d);
    return {{(SUM_W-DATA_W){d[DATA_W-1]}}, d};
  endfunction

  // clip a wide value to signed 32 bits
  function automatic sat_t sat32(input wide_t v);
    sat_t r;
    if (v[WIDE_W-1:DATA_W-1] != {(WIDE_W-DATA_W+1){v[WIDE_W-1]}}) begin
      r.clip = 1'b1;
      r.val  = v[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r.clip = 1'b0;
      r.val  = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/rk4c_if.sv
// item channel interfaces: command in, result out
interface rk4c_cmd_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface rk4c_res_if;
  logic                             valid;
  logic                             ready;
  logic [rk4c_pkg::TIME_W-1:0]        sim_time;
  logic signed [rk4c_pkg::DATA_W-1:0] pos_x;
  logic signed [rk4c_pkg::DATA_W-1:0] pos_y;
  logic signed [rk4c_pkg::DATA_W-1:0] vel_x;
  logic signed [rk4c_pkg::DATA_W-1:0] vel_y;
  logic                             saturated;
  logic                             last;

  modport source (output valid, output sim_time, output pos_x, output pos_y,
                  output vel_x, output vel_y, output saturated, output last,
                  input ready);
  modport sink (input valid, input sim_time, input pos_x, input pos_y,
                input vel_x, input vel_y, input saturated, input last,
                output ready);
endinterface

FILE: design/rk4c_mul.sv
// shared signed multiplier with round-to-nearest q24 scaling, registered output
module rk4c_mul (
  input  logic            clk,
  input  rk4c_pkg::opnd_t a,
  input  rk4c_pkg::opnd_t b,
  output rk4c_pkg::prod_t q
);

  logic signed [2*rk4c_pkg::OPND_W-1:0] full;
  logic signed [2*rk4c_pkg::OPND_W-1:0] rnd;

  // exact product, add half an lsb, floor shift
  assign full = a * b;
  assign rnd  = full + ((2*rk4c_pkg::OPND_W)'(1) <<< (rk4c_pkg::Q_FRAC - 1));

  always_ff @(posedge clk) begin
    q <= rnd[2*rk4c_pkg::OPND_W-1:rk4c_pkg::Q_FRAC];
  end

endmodule

FILE: design/rk4c_div6.sv
// four-lane divide by six, rounded half away from zero, seven bits per cycle
module rk4c_div6 (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  rk4c_pkg::sum_t  sums [4],
  output rk4c_pkg::opnd_t quot [4],
  output logic            busy
);

  localparam int NUM_W     = rk4c_pkg::SUM_W - 1;
  localparam int DIV_BITS  = 7;
  localparam int DIV_STEPS = NUM_W / DIV_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [3:0] DIVISOR = 4'd6;

  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num [4];
  logic [NUM_W-1:0] num_next [4];
  logic [2:0]       rem [4];
  logic [2:0]       rem_next [4];
  logic             neg [4];
  logic [NUM_W-1:0] mag [4];

  // magnitude plus three, so the floor quotient rounds half away from zero
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (sums[i] < 0) begin
        mag[i] = NUM_W'(-sums[i]) + NUM_W'(3);
      end else begin
        mag[i] = NUM_W'(sums[i]) + NUM_W'(3);
      end
    end
  end

  // restoring long division, quotient bits shift into the low end
  always_comb begin
    logic [NUM_W-1:0] n;
    logic [2:0]       r;
    logic [3:0]       rr;
    for (int i = 0; i < 4; i++) begin
      n = num[i];
      r = rem[i];
      for (int j = 0; j < DIV_BITS; j++) begin
        rr = {r, n[NUM_W-1]};
        n  = {n[NUM_W-2:0], 1'b0};
        if (rr >= DIVISOR) begin
          r    = 3'(rr - DIVISOR);
          n[0] = 1'b1;
        end else begin
          r = rr[2:0];
        end
      end
      num_next[i] = n;
      rem_next[i] = r;
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // lane registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (start) begin
        num[i] <= mag[i];
        rem[i] <= '0;
        neg[i] <= sums[i][rk4c_pkg::SUM_W-1];
      end else if (busy) begin
        num[i] <= num_next[i];
        rem[i] <= rem_next[i];
      end
    end
  end

  // restore the sign
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (neg[i]) begin
        quot[i] = -num[i][rk4c_pkg::OPND_W-1:0];
      end else begin
        quot[i] = num[i][rk4c_pkg::OPND_W-1:0];
      end
    end
  end

endmodule

FILE: design/rk4c_core.sv
// rk4 sequencer and state datapath around the shared multiplier
module rk4c_core (
  input  logic            clk,
  input  logic            rst,
  input  rk4c_pkg::cfg_t  cfg,
  input  rk4c_pkg::ctrl_t ctrl,
  output rk4c_pkg::stat_t stat,
  output rk4c_pkg::res_t  result
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_INIT = 5'd1;
  localparam logic [4:0] ST_D0   = 5'd2;
  localparam logic [4:0] ST_D1   = 5'd3;
  localparam logic [4:0] ST_D2   = 5'd4;
  localparam logic [4:0] ST_D3   = 5'd5;
  localparam logic [4:0] ST_A0   = 5'd6;
  localparam logic [4:0] ST_A1   = 5'd7;
  localparam logic [4:0] ST_A2   = 5'd8;
  localparam logic [4:0] ST_A3   = 5'd9;
  localparam logic [4:0] ST_WAIT = 5'd10;
  localparam logic [4:0] ST_SUM  = 5'd11;
  localparam logic [4:0] ST_DIVS = 5'd12;
  localparam logic [4:0] ST_DIV  = 5'd13;
  localparam logic [4:0] ST_F0   = 5'd14;
  localparam logic [4:0] ST_F1   = 5'd15;
  localparam logic [4:0] ST_F2   = 5'd16;
  localparam logic [4:0] ST_F3   = 5'd17;
  localparam logic [4:0] ST_FWB  = 5'd18;
  localparam logic [4:0] ST_DONE = 5'd19;

  localparam logic [1:0] LAST_STAGE = 2'd3;
  localparam logic [1:0] FULL_STAGE = 2'd2;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [4:0] wb_state;
  logic [1:0] stage;
  logic [1:0] wb_stage;

  rk4c_pkg::data_t y [4];
  rk4c_pkg::data_t t [4];
  rk4c_pkg::data_t kvx;
  rk4c_pkg::data_t kvy;
  rk4c_pkg::wide_t acc;
  rk4c_pkg::sum_t  sum [4];
  logic [rk4c_pkg::TIME_W-1:0] cur_time;
  logic                        clip;

  rk4c_pkg::opnd_t mul_a;
  rk4c_pkg::opnd_t mul_b;
  rk4c_pkg::opnd_t h_full;
  rk4c_pkg::opnd_t h_sel;
  rk4c_pkg::prod_t prod;
  rk4c_pkg::opnd_t quot [4];
  logic            div_busy;
  logic            div_start;

  rk4c_pkg::wide_t pext;
  rk4c_pkg::wide_t wb_lhs;
  rk4c_pkg::wide_t wb_rhs;
  rk4c_pkg::sat_t  wb_sat;
  logic [1:0]      wb_idx;
  logic            wb_is_sat;
  rk4c_pkg::data_t wb_kval;
  rk4c_pkg::sum_t  wb_addend;
  logic [rk4c_pkg::TIME_W:0] time_inc;
  logic [rk4c_pkg::TIME_W:0] time_ahead;

  rk4c_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .q   (prod)
  );

  rk4c_div6 u_div6 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sums  (sum),
    .quot  (quot),
    .busy  (div_busy)
  );

  // step sizes: h for the third advance and the update, h/2 otherwise
  assign h_full = {{(rk4c_pkg::OPND_W-rk4c_pkg::STEP_W){1'b0}}, cfg.step_size};
  assign h_sel  = (stage == FULL_STAGE) ? h_full :
                  {{(rk4c_pkg::OPND_W-rk4c_pkg::STEP_W+1){1'b0}},
                   cfg.step_size[rk4c_pkg::STEP_W-1:1]};
  assign div_start = (state == ST_DIVS);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (ctrl.start) begin
          state_next = ctrl.restart ? ST_DONE : ST_INIT;
        end
      end
      ST_INIT: state_next = ST_D0;
      ST_D0:   state_next = ST_D1;
      ST_D1:   state_next = ST_D2;
      ST_D2:   state_next = ST_D3;
      ST_D3:   state_next = (stage == LAST_STAGE) ? ST_WAIT : ST_A0;
      ST_A0:   state_next = ST_A1;
      ST_A1:   state_next = ST_A2;
      ST_A2:   state_next = ST_A3;
      ST_A3:   state_next = ST_D0;
      ST_WAIT: state_next = ST_SUM;
      ST_SUM:  state_next = ST_DIVS;
      ST_DIVS: state_next = ST_DIV;
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_F0;
        end
      end
      ST_F0:   state_next = ST_F1;
      ST_F1:   state_next = ST_F2;
      ST_F2:   state_next = ST_F3;
      ST_F3:   state_next = ST_FWB;
      ST_FWB:  state_next = ST_DONE;
      ST_DONE: begin
        if (ctrl.take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // multiplier operand select per issue slot
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_D0: begin
        mul_a = rk4c_pkg::ext_op(cfg.stiffness_coeff);
        mul_b = rk4c_pkg::ext_op(t[0]);
      end
      ST_D1: begin
        mul_a = rk4c_pkg::ext_op(cfg.coupling_coeff);
        mul_b = rk4c_pkg::ext_op(t[3]);
      end
      ST_D2: begin
        mul_a = rk4c_pkg::ext_op(cfg.stiffness_coeff);
        mul_b = rk4c_pkg::ext_op(t[1]);
      end
      ST_D3: begin
        mul_a = rk4c_pkg::ext_op(cfg.coupling_coeff);
        mul_b = rk4c_pkg::ext_op(t[2]);
      end
      ST_A0: begin
        mul_a = h_sel;
        mul_b = rk4c_pkg::ext_op(t[2]);
      end
      ST_A1: begin
        mul_a = h_sel;
        mul_b = rk4c_pkg::ext_op(t[3]);
      end
      ST_A2: begin
        mul_a = h_sel;
        mul_b = rk4c_pkg::ext_op(kvx);
      end
      ST_A3: begin
        mul_a = h_sel;
        mul_b = rk4c_pkg::ext_op(kvy);
      end
      ST_F0: begin
        mul_a = quot[0];
        mul_b = h_full;
      end
      ST_F1: begin
        mul_a = quot[1];
        mul_b = h_full;
      end
      ST_F2: begin
        mul_a = quot[2];
        mul_b = h_full;
      end
      ST_F3: begin
        mul_a = quot[3];
        mul_b = h_full;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // writeback lane and derivative term of the slot issued last cycle
  always_comb begin
    wb_idx    = 2'd0;
    wb_is_sat = 1'b0;
    wb_kval   = t[2];
    case (wb_state)
      ST_D1, ST_D3: wb_is_sat = 1'b1;
      ST_A0: begin
        wb_idx    = 2'd0;
        wb_is_sat = 1'b1;
        wb_kval   = t[2];
      end
      ST_A1: begin
        wb_idx    = 2'd1;
        wb_is_sat = 1'b1;
        wb_kval   = t[3];
      end
      ST_A2: begin
        wb_idx    = 2'd2;
        wb_is_sat = 1'b1;
        wb_kval   = kvx;
      end
      ST_A3: begin
        wb_idx    = 2'd3;
        wb_is_sat = 1'b1;
        wb_kval   = kvy;
      end
      ST_F0: begin
        wb_idx    = 2'd0;
        wb_is_sat = 1'b1;
      end
      ST_F1: begin
        wb_idx    = 2'd1;
        wb_is_sat = 1'b1;
      end
      ST_F2: begin
        wb_idx    = 2'd2;
        wb_is_sat = 1'b1;
      end
      ST_F3: begin
        wb_idx    = 2'd3;
        wb_is_sat = 1'b1;
      end
      default: begin
        wb_idx    = 2'd0;
        wb_is_sat = 1'b0;
      end
    endcase
  end

  // one shared wide add and clip for every writeback but the accumulator loads
  assign pext   = rk4c_pkg::ext_prod(prod);
  assign wb_lhs = (wb_state == ST_D1 || wb_state == ST_D3) ? acc :
                  rk4c_pkg::ext_wide(y[wb_idx]);
  assign wb_rhs = (wb_state == ST_D3) ? -pext : pext;
  assign wb_sat = rk4c_pkg::sat32(wb_lhs + wb_rhs);

  // k2 and k3 enter the weighted sum twice
  assign wb_addend = (wb_stage == 2'd0) ? rk4c_pkg::ext_sum(wb_kval) :
                     (rk4c_pkg::ext_sum(wb_kval) <<< 1);

  // time advance and end look-ahead
  assign time_inc   = {1'b0, cur_time} +
                      {{(rk4c_pkg::TIME_W-rk4c_pkg::STEP_W+1){1'b0}}, cfg.step_size};
  assign time_ahead = time_inc;

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wb_state <= ST_IDLE;
      stage    <= '0;
      wb_stage <= '0;
      for (int i = 0; i < 4; i++) begin
        y[i] <= '0;
      end
      cur_time <= '0;
      clip     <= 1'b0;
    end else begin
      state    <= state_next;
      wb_state <= state;
      wb_stage <= stage;
      if (state == ST_INIT) begin
        stage <= '0;
      end else if (state == ST_A3) begin
        stage <= stage + 2'd1;
      end
      case (state)
        ST_IDLE: begin
          if (ctrl.start && ctrl.restart) begin
            y[0]     <= cfg.init_pos_x;
            y[1]     <= cfg.init_pos_y;
            y[2]     <= cfg.init_vel_x;
            y[3]     <= cfg.init_vel_y;
            cur_time <= '0;
            clip     <= 1'b0;
          end
        end
        ST_INIT: begin
          cur_time <= time_inc[rk4c_pkg::TIME_W] ? '1 : time_inc[rk4c_pkg::TIME_W-1:0];
          clip     <= time_inc[rk4c_pkg::TIME_W];
        end
        default: begin
          if (wb_is_sat && wb_sat.clip) begin
            clip <= 1'b1;
          end
        end
      endcase
      // state update from the final products
      case (wb_state)
        ST_F0, ST_F1, ST_F2, ST_F3: y[wb_idx] <= wb_sat.val;
        default: ;
      endcase
    end
  end

  // scratch registers of one step
  always_ff @(posedge clk) begin
    if (state == ST_INIT) begin
      for (int i = 0; i < 4; i++) begin
        t[i]   <= y[i];
        sum[i] <= '0;
      end
    end
    if (state == ST_SUM) begin
      sum[0] <= sum[0] + rk4c_pkg::ext_sum(t[2]);
      sum[1] <= sum[1] + rk4c_pkg::ext_sum(t[3]);
      sum[2] <= sum[2] + rk4c_pkg::ext_sum(kvx);
      sum[3] <= sum[3] + rk4c_pkg::ext_sum(kvy);
    end
    case (wb_state)
      ST_D0, ST_D2: acc <= -pext;
      ST_D1:        kvx <= wb_sat.val;
      ST_D3:        kvy <= wb_sat.val;
      ST_A0, ST_A1, ST_A2, ST_A3: begin
        t[wb_idx]   <= wb_sat.val;
        sum[wb_idx] <= sum[wb_idx] + wb_addend;
      end
      default: ;
    endcase
  end

  // status and result
  assign stat.idle = (state == ST_IDLE);
  assign stat.done = (state == ST_DONE);

  assign result.sim_time  = cur_time;
  assign result.pos_x     = y[0];
  assign result.pos_y     = y[1];
  assign result.vel_x     = y[2];
  assign result.vel_y     = y[3];
  assign result.saturated = clip;
  assign result.last      = (time_ahead > {1'b0, cfg.end_time});

endmodule

FILE: design/rk4_coupled_oscillator_step.sv
// rk4 coupled oscillator integrator: top level with configuration and result register
// a step item runs 32 issue slots of the one shared multiplier, a divide by six and
// the final update; a restart item loads the initial state and goes straight to done
// a new item is taken only while the sequencer is idle
// the result register holds a finished item until the sink takes it
// synchronous active-high reset loads register defaults and clears state and time to zero
module rk4_coupled_oscillator_step (
  input  logic                               clk,
  input  logic                               rst,
  rk4c_cmd_if.sink                           cmd,
  rk4c_res_if.source                         res,
  input  logic                               cfg_wen,
  input  logic [rk4c_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [rk4c_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rk4c_pkg::cfg_t  cfg;
  rk4c_pkg::ctrl_t ctrl;
  rk4c_pkg::stat_t stat;
  rk4c_pkg::res_t  result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_size       <= rk4c_pkg::RST_STEP_SIZE;
      cfg.coupling_coeff  <= rk4c_pkg::RST_COUPLING;
      cfg.stiffness_coeff <= rk4c_pkg::RST_STIFFNESS;
      cfg.init_pos_x      <= rk4c_pkg::RST_INIT_POS_X;
      cfg.init_pos_y      <= '0;
      cfg.init_vel_x      <= '0;
      cfg.init_vel_y      <= '0;
      cfg.end_time        <= rk4c_pkg::RST_END_TIME;
    end else if (cfg_wen) begin
      case (cfg_idx)
        rk4c_pkg::REG_STEP_SIZE:  cfg.step_size       <= cfg_data[rk4c_pkg::STEP_W-1:0];
        rk4c_pkg::REG_COUPLING:   cfg.coupling_coeff  <= cfg_data[rk4c_pkg::DATA_W-1:0];
        rk4c_pkg::REG_STIFFNESS:  cfg.stiffness_coeff <= cfg_data[rk4c_pkg::DATA_W-1:0];
        rk4c_pkg::REG_INIT_POS_X: cfg.init_pos_x      <= cfg_data[rk4c_pkg::DATA_W-1:0];
        rk4c_pkg::REG_INIT_POS_Y: cfg.init_pos_y      <= cfg_data[rk4c_pkg::DATA_W-1:0];
        rk4c_pkg::REG_INIT_VEL_X: cfg.init_vel_x      <= cfg_data[rk4c_pkg::DATA_W-1:0];
        rk4c_pkg::REG_INIT_VEL_Y: cfg.init_vel_y      <= cfg_data[rk4c_pkg::DATA_W-1:0];
        rk4c_pkg::REG_END_TIME:   cfg.end_time        <= cfg_data[rk4c_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake to the sequencer
  assign cmd.ready    = stat.idle;
  assign ctrl.start   = cmd.valid && cmd.ready;
  assign ctrl.restart = cmd.restart;
  assign ctrl.take    = !res.valid || res.ready;

  rk4c_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .ctrl   (ctrl),
    .stat   (stat),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (stat.done && ctrl.take) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && ctrl.take) begin
      res.sim_time  <= result.sim_time;
      res.pos_x     <= result.pos_x;
      res.pos_y     <= result.pos_y;
      res.vel_x     <= result.vel_x;
      res.vel_y     <= result.vel_y;
      res.saturated <= result.saturated;
      res.last      <= result.last;
    end
  end

  // sequencer leaves idle right after an accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("sequencer still idle after accepting an item");

  // a result appears only out of the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(stat.done))
    else $error("result raised without a finished item");

  // a finished item waits until the result register is free
  a_done_held: assert property (@(posedge clk) disable iff (rst)
    (stat.done && !ctrl.take) |=> stat.done)
    else $error("finished item dropped while the result register was full");

endmodule

FILE: sim/tb_top.sv
// testbench of the rk4 coupled oscillator integrator: directed and random items checked against a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rk4c_pkg::*;

  localparam longint      S32_HI    = 64'sd2147483647;
  localparam longint      S32_LO    = -64'sd2147483648;
  localparam longint      HALF_LSB  = 64'sd1 <<< (Q_FRAC - 1);
  localparam logic [63:0] TIME_CEIL = 64'hFFFF_FFFF_FFFF;
  localparam data_t       DATA_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t       DATA_MIN  = {1'b1, {(DATA_W-1){1'b0}}};

  typedef longint vec4_t [4];

  // predicted oscillator state and the queue of expected step results
  class state_checker;
    logic [STEP_W-1:0] step_reg;
    longint            coup;
    longint            stiff;
    vec4_t             init_val;
    logic [TIME_W-1:0] end_reg;
    vec4_t             cur;
    logic [63:0]       now;
    bit                clipped;
    res_t              expected_states[$];
    int unsigned       errors;

    function new();
      step_reg    = RST_STEP_SIZE;
      coup        = RST_COUPLING;
      stiff       = RST_STIFFNESS;
      init_val[0] = RST_INIT_POS_X;
      init_val[1] = 0;
      init_val[2] = 0;
      init_val[3] = 0;
      end_reg     = RST_END_TIME;
      for (int i = 0; i < 4; i++) cur[i] = 0;
      now     = '0;
      clipped = 1'b0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      data_t d;
      d = val[DATA_W-1:0];
      case (idx)
        REG_STEP_SIZE:  step_reg = val[STEP_W-1:0];
        REG_COUPLING:   coup = d;
        REG_STIFFNESS:  stiff = d;
        REG_INIT_POS_X: init_val[0] = d;
        REG_INIT_POS_Y: init_val[1] = d;
        REG_INIT_VEL_X: init_val[2] = d;
        REG_INIT_VEL_Y: init_val[3] = d;
        REG_END_TIME:   end_reg = val[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > S32_HI) begin
        clipped = 1'b1;
        return S32_HI;
      end
      if (v < S32_LO) begin
        clipped = 1'b1;
        return S32_LO;
      end
      return v;
    endfunction

    // q8.24 product, round half up
    function longint rmul(longint a, longint b);
      return (a * b + HALF_LSB) >>> Q_FRAC;
    endfunction

    // derivative of (px, py, vx, vy)
    function void slope(input vec4_t y, output vec4_t d);
      d[0] = y[2];
      d[1] = y[3];
      d[2] = clamp32(rmul(coup, y[3]) - rmul(stiff, y[0]));
      d[3] = clamp32(-rmul(coup, y[2]) - rmul(stiff, y[1]));
    endfunction

    // intermediate state cur + gain * k
    function void nudge(input vec4_t k, input longint gain, output vec4_t y);
      for (int i = 0; i < 4; i++) y[i] = clamp32(cur[i] + rmul(gain, k[i]));
    endfunction

    function void note_cmd(logic restart);
      vec4_t  k1, k2, k3, k4, mid;
      longint h, hh, s, a;
      res_t   e;
      clipped = 1'b0;
      if (restart) begin
        cur = init_val;
        now = '0;
      end else begin
        h  = longint'(step_reg);
        hh = longint'(step_reg >> 1);
        slope(cur, k1);
        nudge(k1, hh, mid);
        slope(mid, k2);
        nudge(k2, hh, mid);
        slope(mid, k3);
        nudge(k3, h, mid);
        slope(mid, k4);
        // weighted sum divided by six, rounded away from zero on ties
        for (int i = 0; i < 4; i++) begin
          s = k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i];
          a = ((s < 0 ? -s : s) + 3) / 6;
          if (s < 0) a = -a;
          mid[i] = clamp32(cur[i] + rmul(a, h));
        end
        cur = mid;
        now = now + 64'(step_reg);
        if (now > TIME_CEIL) begin
          now     = TIME_CEIL;
          clipped = 1'b1;
        end
      end
      e.sim_time  = now[TIME_W-1:0];
      e.pos_x     = cur[0][DATA_W-1:0];
      e.pos_y     = cur[1][DATA_W-1:0];
      e.vel_x     = cur[2][DATA_W-1:0];
      e.vel_y     = cur[3][DATA_W-1:0];
      e.saturated = clipped;
      e.last      = (now + 64'(step_reg)) > 64'(end_reg);
      expected_states.push_back(e);
    endfunction

    function void compare(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_states.size() == 0) begin
        $error("result with no item pending: sim_time %0d", got.sim_time);
        errors++;
        return;
      end
      want = expected_states.pop_front();
      compare("sim_time", want.sim_time, got.sim_time);
      compare("pos_x", want.pos_x, got.pos_x);
      compare("pos_y", want.pos_y, got.pos_y);
      compare("vel_x", want.vel_x, got.vel_x);
      compare("vel_y", want.vel_y, got.vel_y);
      compare("saturated", want.saturated, got.saturated);
      compare("last", want.last, got.last);
    endfunction

    function int unsigned pending();
      return expected_states.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rk4c_cmd_if cmd_ch ();
  rk4c_res_if res_ch ();

  rk4_coupled_oscillator_step u_top (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .res      (res_ch),
    .cfg_wen  (cfg_wen),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  state_checker tracker = new();
  int unsigned  hold_left;
  int unsigned  cmds_sent;
  bit           calm;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result sink: random stalls, long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 24);
      end
      @(posedge clk);
    end
  end

  // observe accepted items on both channels
  always @(posedge clk) begin
    res_t got;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) tracker.note_cmd(cmd_ch.restart);
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.sim_time, res_ch.pos_x, res_ch.pos_y, res_ch.vel_x, res_ch.vel_y,
               res_ch.saturated, res_ch.last};
        tracker.check_result(got);
      end
    end
  end

  function automatic data_t spread(input int unsigned span);
    return data_t'($urandom_range(0, 2 * span)) - data_t'(span);
  endfunction

  // offer one item, then maybe go quiet for a while
  task automatic send_cmd(input logic restart);
    cmd_ch.valid   <= 1'b1;
    cmd_ch.restart <= restart;
    do @(posedge clk); while (!cmd_ch.ready);
    cmds_sent++;
    if (!calm && $urandom_range(0, 99) < 24) begin
      cmd_ch.valid   <= 1'b0;
      cmd_ch.restart <= 1'($urandom);
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wen  <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  // write the selected registers, junk in the unused upper data bits
  task automatic program_regs(input cfg_t c, input logic [7:0] which);
    if (which[REG_STEP_SIZE])  put_reg(REG_STEP_SIZE, {17'($urandom), c.step_size});
    if (which[REG_COUPLING])   put_reg(REG_COUPLING, {16'($urandom), c.coupling_coeff});
    if (which[REG_STIFFNESS])  put_reg(REG_STIFFNESS, {16'($urandom), c.stiffness_coeff});
    if (which[REG_INIT_POS_X]) put_reg(REG_INIT_POS_X, {16'($urandom), c.init_pos_x});
    if (which[REG_INIT_POS_Y]) put_reg(REG_INIT_POS_Y, {16'($urandom), c.init_pos_y});
    if (which[REG_INIT_VEL_X]) put_reg(REG_INIT_VEL_X, {16'($urandom), c.init_vel_x});
    if (which[REG_INIT_VEL_Y]) put_reg(REG_INIT_VEL_Y, {16'($urandom), c.init_vel_y});
    if (which[REG_END_TIME])   put_reg(REG_END_TIME, c.end_time);
    cfg_wen <= 1'b0;
  endtask

  // stimulus
  initial begin
    cfg_t        c;
    int unsigned n;
    int unsigned phase;
    bit          wild;
    rst            <= 1'b1;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.restart <= 1'b0;
    cfg_wen        <= 1'b0;
    cfg_idx        <= REG_STEP_SIZE;
    cfg_data       <= '0;
    calm      = 1'b0;
    hold_left = 0;
    cmds_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers: steps from the all-zero state, then restart and integrate
    send_cmd(1'b0);
    send_cmd(1'b0);
    send_cmd(1'b1);
    repeat (4) send_cmd(1'b0);
    drain();

    // largest step, extreme coefficients and states, end time zero
    c.step_size       = '1;
    c.coupling_coeff  = DATA_MAX;
    c.stiffness_coeff = DATA_MIN;
    c.init_pos_x      = DATA_MAX;
    c.init_pos_y      = DATA_MIN;
    c.init_vel_x      = DATA_MIN;
    c.init_vel_y      = DATA_MAX;
    c.end_time        = '0;
    program_regs(c, 8'hFF);
    send_cmd(1'b1);
    repeat (3) send_cmd(1'b0);
    drain();

    // zero step: nothing advances, end time at its maximum
    c.step_size       = '0;
    c.coupling_coeff  = DATA_MIN;
    c.stiffness_coeff = DATA_MAX;
    c.init_pos_x      = data_t'($urandom);
    c.init_pos_y      = data_t'($urandom);
    c.init_vel_x      = data_t'($urandom);
    c.init_vel_y      = data_t'($urandom);
    c.end_time        = '1;
    program_regs(c, 8'hFF);
    send_cmd(1'b1);
    repeat (2) send_cmd(1'b0);
    drain();

    // smallest nonzero step, last rises after a few steps and stays up
    c.step_size       = STEP_W'(1);
    c.coupling_coeff  = spread(32'h0080_0000);
    c.stiffness_coeff = spread(32'h0200_0000);
    c.init_pos_x      = spread(32'h1000_0000);
    c.init_pos_y      = spread(32'h1000_0000);
    c.init_vel_x      = spread(32'h0400_0000);
    c.init_vel_y      = spread(32'h0400_0000);
    c.end_time        = TIME_W'(3);
    program_regs(c, 8'hFF);
    send_cmd(1'b1);
    repeat (5) send_cmd(1'b0);
    drain();

    // random phases: a restart followed by a run of steps
    phase = 0;
    while (cmds_sent < 750) begin
      wild = ($urandom_range(0, 99) < 30);
      if (wild) begin
        c.step_size       = STEP_W'($urandom);
        c.coupling_coeff  = data_t'($urandom);
        c.stiffness_coeff = data_t'($urandom);
        c.init_pos_x      = data_t'($urandom);
        c.init_pos_y      = data_t'($urandom);
        c.init_vel_x      = data_t'($urandom);
        c.init_vel_y      = data_t'($urandom);
        c.end_time        = TIME_W'({$urandom, $urandom});
      end else begin
        c.step_size       = STEP_W'($urandom_range(1, 32'h0100_0000));
        c.coupling_coeff  = spread(32'h0080_0000);
        c.stiffness_coeff = spread(32'h0200_0000);
        c.init_pos_x      = spread(32'h1000_0000);
        c.init_pos_y      = spread(32'h1000_0000);
        c.init_vel_x      = spread(32'h0400_0000);
        c.init_vel_y      = spread(32'h0400_0000);
        c.end_time        = 48'(c.step_size) * $urandom_range(0, 60) + $urandom_range(0, 1);
      end
      program_regs(c, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF);
      calm = (phase == 3);
      n = $urandom_range(20, 60);
      for (int j = 0; j < n; j++) begin
        // mid-run pause until the block is empty
        if (j == n / 2 && (phase == 1 || $urandom_range(0, 9) == 0)) drain();
        // sink holds off while items keep coming
        if (j == 5 && phase == 2) hold_left = 300;
        send_cmd(j == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) < 6));
      end
      drain();
      calm = 1'b0;
      phase++;
    end

    // watch for stray results
    repeat (60) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
